// ===== rtl/sha256_pkg.sv =====
// SHA-256 shared types, round constants and round functions.
// No dependencies; used by the controller, datapath and top level.
package sha256_pkg;

  localparam int unsigned DigestWords = 8;

  typedef struct packed {
    logic load_byte;
    logic pad_byte;
    logic len_byte;
    logic zero_byte;
    logic start_block;
    logic round_step;
    logic add_hash;
    logic reset_hash;
    logic clear_count;
  } sha_cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/sha256_message_hash_top.sv =====
// SHA-256 byte-stream hasher, top level.
// Depends on sha256_pkg, sha256_ctrl and sha256_dp.
//
//  channel | dir | tdata                  | tuser
//  in_     | in  | data_byte[7:0]         | has_byte[0], end_of_message[1]
//  out_    | out | digest_word[31:0]      | word_index[2:0], last_word via tlast
//
// A byte item is taken while idle; a byte that fills a block holds the input
// through the 64 rounds of the single shared round unit and the hash add.
// An ending item adds the 0x80/zero/length fill, then the rounds and hash add
// for each padding block, then 8 output beats.
// Reset clears control and count and loads the initial hash words. Input stalls while busy;
// output holds each word until taken.
module sha256_message_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [0] has_byte, [1] end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast
);

  sha256_pkg::sha_cmd_t cmd;
  logic [5:0] fill_pos, round_idx;
  logic [2:0] out_idx;
  logic in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign out_tuser = out_idx;
  assign out_tlast = (out_idx == 3'd7);

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_has_byte(in_tuser[0]), .in_eom(in_tuser[1]),
    .fill_pos, .out_fire, .in_ready(in_tready), .out_valid(out_tvalid),
    .out_idx, .round_idx, .cmd
  );

  sha256_dp u_dp (
    .clk, .rst_n, .cmd, .in_byte(in_tdata), .round_idx, .out_idx,
    .fill_pos, .digest_word(out_tdata)
  );

endmodule

// ===== rtl/sha256_ctrl.sv =====
// SHA-256 controller: sequences byte loading, padding, rounds and digest output.
// Depends on sha256_pkg.
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 in_has_byte,
  input  logic                 in_eom,
  input  logic [5:0]           fill_pos,
  input  logic                 out_fire,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic [2:0]           out_idx,
  output logic [5:0]           round_idx,
  output sha256_pkg::sha_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUND, S_ADD, S_PAD, S_ZERO, S_LEN, S_OUT
  } state_t;

  state_t     state_r;
  logic [5:0] round_r;
  logic [2:0] len_r;
  logic [2:0] idx_r;
  logic       final_r;   // block being compressed is the last of the message
  logic       eom_r;     // end seen with the byte that filled a block
  logic       zfill_r;   // padding spilt into a second block: zero fill goes on

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = idx_r;
  assign round_idx = round_r;

  always_comb begin
    cmd = '0;
    cmd.load_byte  = in_fire && in_has_byte;
    cmd.round_step = (state_r == S_ROUND);
    cmd.add_hash   = (state_r == S_ADD);
    cmd.pad_byte   = (state_r == S_PAD);
    cmd.zero_byte  = (state_r == S_ZERO);
    cmd.len_byte   = (state_r == S_LEN);
    cmd.reset_hash = out_fire && (idx_r == 3'd7);
    cmd.clear_count = cmd.reset_hash;
    cmd.start_block = (state_r == S_IDLE && in_fire && in_has_byte && fill_pos == 6'd63)
                   || (state_r == S_PAD && fill_pos == 6'd63)
                   || (state_r == S_ZERO && fill_pos == 6'd63)
                   || (state_r == S_LEN && len_r == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      round_r <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      final_r <= 1'b0;
      eom_r   <= 1'b0;
      zfill_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_has_byte && fill_pos == 6'd63) begin
              state_r <= S_ROUND;
              round_r <= '0;
              final_r <= 1'b0;
              eom_r   <= in_eom;
            end else if (in_eom) begin
              state_r <= S_PAD;
            end
          end
        end
        S_ROUND: begin
          round_r <= round_r + 6'd1;
          if (round_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          if (final_r) begin
            state_r <= S_OUT;
            idx_r   <= '0;
          end else if (eom_r) begin
            eom_r   <= 1'b0;
            state_r <= S_PAD;
          end else if (zfill_r) begin
            zfill_r <= 1'b0;
            state_r <= S_ZERO;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          // 0x80 in the last slot closes the block; in slot 55 the length follows
          if (fill_pos == 6'd63) begin
            state_r <= S_ROUND;
            round_r <= '0;
            final_r <= 1'b0;
            zfill_r <= 1'b1;
          end else if (fill_pos == 6'd55) begin
            state_r <= S_LEN;
            len_r   <= '0;
          end else begin
            state_r <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (fill_pos == 6'd63) begin
            state_r <= S_ROUND;
            round_r <= '0;
            final_r <= 1'b0;
            zfill_r <= 1'b1;
          end else if (fill_pos == 6'd55) begin
            state_r <= S_LEN;
            len_r   <= '0;
          end
        end
        S_LEN: begin
          len_r <= len_r + 3'd1;
          if (len_r == 3'd7) begin
            state_r <= S_ROUND;
            round_r <= '0;
            final_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              state_r <= S_IDLE;
              final_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("output while accepting input");
  a_round_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && round_r == 6'd63) |=> state_r == S_ADD)
    else $error("round count did not end in add");
  a_idx_zero_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> idx_r == 3'd0) else $error("digest did not start at word 0");
`endif

endmodule

// ===== rtl/sha256_dp.sv =====
// SHA-256 datapath: byte-packed schedule window, round registers, hash words, count.
// Depends on sha256_pkg; driven by sha256_ctrl.
module sha256_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::sha_cmd_t cmd,
  input  logic [7:0]           in_byte,
  input  logic [5:0]           round_idx,
  input  logic [2:0]           out_idx,
  output logic [5:0]           fill_pos,
  output logic [31:0]          digest_word
);

  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [60:0] count_r;
  logic [5:0]  pos_r;     // write pointer for padding and bytes

  logic [63:0] bits;
  logic [7:0]  wbyte;
  logic [31:0] w_cur, sg0, sg1, s0, s1, ch, maj, t1, t2;

  assign fill_pos    = pos_r;
  assign digest_word = h_r[out_idx];
  assign bits        = {count_r, 3'b000};

  always_comb begin
    wbyte = in_byte;
    if (cmd.pad_byte) wbyte = 8'h80;
    else if (cmd.zero_byte) wbyte = 8'h00;
    else if (cmd.len_byte) wbyte = bits[{~pos_r[2:0], 3'b000} +: 8];
  end

  always_comb begin
    sg1 = sha256_pkg::rotr(w_r[14], 17) ^ sha256_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    sg0 = sha256_pkg::rotr(w_r[1], 7) ^ sha256_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    w_cur = (round_idx < 6'd16) ? w_r[0] : (sg1 + w_r[9] + sg0 + w_r[0]);
    s1 = sha256_pkg::rotr(v_r[4], 6) ^ sha256_pkg::rotr(v_r[4], 11)
       ^ sha256_pkg::rotr(v_r[4], 25);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + sha256_pkg::round_k(round_idx) + w_cur;
    s0 = sha256_pkg::rotr(v_r[0], 2) ^ sha256_pkg::rotr(v_r[0], 13)
       ^ sha256_pkg::rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + maj;
  end

  // schedule and round registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load_byte || cmd.pad_byte || cmd.zero_byte || cmd.len_byte) begin
      // pack each byte straight into its big-endian schedule word
      w_r[pos_r[5:2]][{~pos_r[1:0], 3'b000} +: 8] <= wbyte;
    end else if (cmd.round_step) begin
      // rotate w[0..15] through once, then slot 0 holds w[t-16], slot 15 w[t-1]
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
    end
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (cmd.round_step) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::init_h(3'(i));
      count_r <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.reset_hash) begin
        for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::init_h(3'(i));
      end else if (cmd.add_hash) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (cmd.clear_count) begin
        count_r <= '0;
        pos_r   <= '0;
      end else begin
        if (cmd.load_byte) count_r <= count_r + 61'd1;
        if (cmd.load_byte || cmd.pad_byte || cmd.zero_byte || cmd.len_byte)
          pos_r <= pos_r + 6'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_byte |=> count_r[5:0] == $past(count_r[5:0]) + 6'd1)
    else $error("byte count lost a byte");
  a_no_load_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_step |-> !cmd.load_byte) else $error("byte written during rounds");
  a_len_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.len_byte |-> pos_r >= 6'd56) else $error("length byte outside tail");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the byte-serial SHA-256 hasher: predicts digests of
// random and edge-length messages and compares every output beat.
// Depends on sha256_message_hash_top and sha256_pkg (DigestWords only).
module tb;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_beat_t;

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] HINIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  sha256_message_hash_top dut (.*);

  // predictor state
  logic [7:0]  blk_bytes [64];
  logic [31:0] hash_acc [8];
  logic [60:0] msg_len;

  msg_item_t    pending_items[$];
  digest_beat_t expected_digests[$];
  int  errors, cycles;
  bit  stim_done, calm;
  int  in_gap, out_gap;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] wt, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = hash_acc[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = (ror(w[(t-2)&15], 17) ^ ror(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10))
           + w[(t-7)&15]
           + (ror(w[(t-15)&15], 7) ^ ror(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3))
           + w[t&15];
        w[t&15] = wt;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + wt;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_acc[i] += v[i];
  endtask

  task automatic absorb_item(msg_item_t it);
    int pos;
    logic [63:0] bitlen;
    digest_beat_t b;
    if (it.has_byte) begin
      blk_bytes[msg_len[5:0]] = it.data_byte;
      msg_len = msg_len + 61'd1;
      if (msg_len[5:0] == 0) compress();
    end
    if (!it.end_of_message) return;
    pos = msg_len[5:0];
    blk_bytes[pos++] = 8'h80;
    if (pos > 56) begin
      while (pos < 64) blk_bytes[pos++] = 8'h00;
      compress();
      pos = 0;
    end
    while (pos < 56) blk_bytes[pos++] = 8'h00;
    bitlen = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) blk_bytes[56+i] = bitlen[63-8*i -: 8];
    compress();
    for (int i = 0; i < sha256_pkg::DigestWords; i++) begin
      b.digest_word = hash_acc[i];
      b.word_index  = i[2:0];
      b.last_word   = (i == 7);
      expected_digests.push_back(b);
    end
    for (int i = 0; i < 8; i++) hash_acc[i] = HINIT[i];
    msg_len = '0;
  endtask

  task automatic push_message(int len, bit tail_has_byte);
    msg_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_byte = 8'($urandom_range(0, 255));
      it.has_byte = 1'b1;
      it.end_of_message = (i == len - 1) && tail_has_byte;
      // drop an empty item in now and then
      if ($urandom_range(0, 19) == 0) pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
      pending_items.push_back(it);
    end
    if (!tail_has_byte || len == 0)
      pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    int n;
    for (int i = 0; i < 8; i++) hash_acc[i] = HINIT[i];
    msg_len = '0;
    // directed: empty message, idle item, extreme bytes, short messages
    pending_items.push_back('{8'hff, 1'b0, 1'b0});
    push_message(0, 1'b1);
    pending_items.push_back('{8'h00, 1'b1, 1'b0});
    pending_items.push_back('{8'hff, 1'b1, 1'b1});
    pending_items.push_back('{8'h55, 1'b1, 1'b0});
    pending_items.push_back('{8'haa, 1'b0, 1'b1});
    push_message(3, 1'b1);
    push_message(7, 1'b0);
    n = 0;
    while (n < 320) begin
      case ($urandom_range(0, 5))
        0: push_message($urandom_range(54, 57), 1'($urandom_range(0, 1)));
        1: push_message($urandom_range(63, 65), 1'($urandom_range(0, 1)));
        2: push_message(119 + $urandom_range(0, 2), 1'b1);
        default: push_message($urandom_range(0, 20), 1'($urandom_range(0, 1)));
      endcase
      n = pending_items.size();
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_item({in_tdata, in_tuser[0], in_tuser[1]});
        void'(pending_items.pop_front());
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!in_tvalid || in_tready) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap <= $urandom_range(0, 4);
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_items[0].data_byte;
          in_tuser  <= {pending_items[0].end_of_message, pending_items[0].has_byte};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        digest_beat_t e;
        if (expected_digests.size() == 0) begin
          $error("unexpected digest beat %h", out_tdata);
          errors++;
        end else begin
          e = expected_digests.pop_front();
          if (out_tdata !== e.digest_word) begin
            $error("digest_word exp %h got %h", e.digest_word, out_tdata);
            errors++;
          end
          if (out_tuser !== e.word_index) begin
            $error("word_index exp %0d got %0d", e.word_index, out_tuser);
            errors++;
          end
          if (out_tlast !== e.last_word) begin
            $error("last_word exp %b got %b", e.last_word, out_tlast);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    // hold off idling over the last stretch of stimulus
    calm <= (pending_items.size() < 40);
    if (cycles > 400000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    calm = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !in_tvalid);
    wait (expected_digests.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
